// ----- rtl/obst_pkg.sv -----
// Shared constants, types and table addressing for the optimal BST solver.
// Used by obst_tables, optimal_bst_cost_and_roots, obst_checker and tb_top.
package obst_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KW        = $clog2(MAX_KEYS + 2);   // key / interval index width
  localparam int WW        = 16;                     // weight width
  localparam int CW        = 28;                     // cost width
  localparam int RW        = 7;                      // root width
  localparam int TBL_DEPTH = (MAX_KEYS + 2) * (MAX_KEYS + 1);
  localparam int TAW       = $clog2(TBL_DEPTH);
  localparam int WAW       = $clog2(MAX_KEYS + 1);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;   // unused, beat is dropped

  localparam logic KIND_SOLVE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic           we_cost;
    logic           we_root;
    logic [TAW-1:0] addr;
    logic [CW-1:0]  cost;
    logic [RW-1:0]  root;
  } tbl_wr_t;

  // row-major (i, j) placement, i in 0..MAX_KEYS+1, j in 0..MAX_KEYS
  function automatic logic [TAW-1:0] tbl_addr(logic [KW-1:0] i, logic [KW-1:0] j);
    return TAW'(int'(i) * (MAX_KEYS + 1) + int'(j));
  endfunction

endpackage

// ----- rtl/obst_tables.sv -----
// Weight store, cost table (two read ports) and root table, all synchronous.
// Depends on obst_pkg.
module obst_tables import obst_pkg::*; (
  input  logic           clk_i,
  input  logic           w_we_i,
  input  logic [WAW-1:0] w_waddr_i,
  input  logic [WW-1:0]  w_wdata_i,
  input  logic [WAW-1:0] w_raddr_i,
  output logic [WW-1:0]  w_rdata_o,
  input  tbl_wr_t        tbl_wr_i,
  input  logic [TAW-1:0] c_raddr_a_i,
  input  logic [TAW-1:0] c_raddr_b_i,
  output logic [CW-1:0]  c_rdata_a_o,
  output logic [CW-1:0]  c_rdata_b_o,
  input  logic [TAW-1:0] r_raddr_i,
  output logic [RW-1:0]  r_rdata_o
);

  logic [WW-1:0] w_mem    [MAX_KEYS + 1];
  logic [CW-1:0] cost_mem [TBL_DEPTH];
  logic [RW-1:0] root_mem [TBL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (w_we_i) begin
      w_mem[w_waddr_i] <= w_wdata_i;
    end
    w_rdata_o <= w_mem[w_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_wr_i.we_cost) begin
      cost_mem[tbl_wr_i.addr] <= tbl_wr_i.cost;
    end
    c_rdata_a_o <= cost_mem[c_raddr_a_i];
    c_rdata_b_o <= cost_mem[c_raddr_b_i];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_wr_i.we_root) begin
      root_mem[tbl_wr_i.addr] <= tbl_wr_i.root;
    end
    r_rdata_o <= root_mem[r_raddr_i];
  end

endmodule

// ----- rtl/optimal_bst_cost_and_roots.sv -----
// Top level: command decode and the diagonal-by-diagonal solve sequencer.
// Depends on obst_pkg and obst_tables.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid/s_axis_tready     tuser command, tdata fields
//  m_axis    out  m_axis_tvalid/m_axis_tready     tuser result_kind, tdata fields
//  cfg       in   cfg_valid_i/cfg_ready_o         key_count
//
// Load: the weight is written at the accept. Query: one root table read, then S_QRD registers the result.
// Solve: after the accept, diagonal init writes each key's weight as its own interval cost;
// then per interval S_RUN, S_DRAIN and S_WRITE (one candidate root per cycle through the cost
// table's two read ports), then S_FIN_RD and S_FIN for the answer. An empty problem answers zero.
// No beat is taken while a result waits on m_axis. Reset leaves tables undefined.
module optimal_bst_cost_and_roots import obst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // key_index[6:0], weight[22:7], range_start[29:23],
                                     // range_end[36:30], zero[39:37]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // min_cost[27:0], root_key[34:28], status[35],
                                     // zero[39:36]
  output logic        m_axis_tuser,  // result_kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_INIT_END, S_RUN, S_DRAIN, S_WRITE, S_FIN_RD, S_FIN, S_QRD
  } state_e;

  state_e          state_q;
  logic [6:0]      key_count_q;
  logic [KW-1:0]   i_q, j_q, k_q, span_q, p_k_q;
  logic            p_v_q, p_lemp_q, p_remp_q;
  logic [CW-1:0]   best_q, sum_q;
  logic [RW-1:0]   broot_q;
  logic            q_ok_q, q_empty_q;
  logic            out_valid_q, out_kind_q, out_status_q;
  logic [CW-1:0]   out_cost_q;
  logic [RW-1:0]   out_root_q;

  logic [1:0]      cmd;
  logic [KW-1:0]   in_key, in_rs, in_re, n_eff;
  logic [WW-1:0]   in_weight;
  logic            in_acc, w_we, q_ok;
  logic [WW-1:0]   w_rdata;
  logic [CW-1:0]   ra, rb, cand;
  logic [RW-1:0]   r_rdata;
  logic [WAW-1:0]  w_raddr;
  logic [TAW-1:0]  c_raddr_a, c_raddr_b, r_raddr;
  tbl_wr_t         tbl_wr;

  assign cmd       = s_axis_tuser;
  assign in_key    = KW'(s_axis_tdata[6:0]);
  assign in_weight = s_axis_tdata[22:7];
  assign in_rs     = KW'(s_axis_tdata[29:23]);
  assign in_re     = KW'(s_axis_tdata[36:30]);

  assign n_eff = (int'(key_count_q) > MAX_KEYS) ? KW'(MAX_KEYS) : KW'(key_count_q);

  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign w_we = in_acc && (cmd == CMD_LOAD) && (in_key != '0) && (int'(in_key) <= MAX_KEYS);

  assign q_ok = (in_rs != '0) && ({1'b0, in_rs} <= {1'b0, n_eff} + 1'b1)
             && ({1'b0, in_re} + 1'b1 >= {1'b0, in_rs}) && (in_re <= n_eff);

  // read addresses
  always_comb begin
    w_raddr   = WAW'(k_q);
    c_raddr_a = tbl_addr(i_q, k_q - 1'b1);
    c_raddr_b = tbl_addr(k_q + 1'b1, j_q);
    if (state_q == S_FIN_RD) begin
      c_raddr_a = tbl_addr(KW'(1), n_eff);
    end
    r_raddr = (state_q == S_IDLE) ? tbl_addr(in_rs, in_re) : tbl_addr(KW'(1), n_eff);
  end

  // table writes: diagonal init, then one per finished interval
  always_comb begin
    tbl_wr = '0;
    if ((state_q == S_INIT && p_v_q) || state_q == S_INIT_END) begin
      tbl_wr.we_cost = 1'b1;
      tbl_wr.we_root = 1'b1;
      tbl_wr.addr    = tbl_addr(p_k_q, p_k_q);
      tbl_wr.cost    = CW'(w_rdata);
      tbl_wr.root    = RW'(p_k_q);
    end else if (state_q == S_WRITE) begin
      tbl_wr.we_cost = 1'b1;
      tbl_wr.we_root = 1'b1;
      tbl_wr.addr    = tbl_addr(i_q, j_q);
      tbl_wr.cost    = best_q + sum_q;
      tbl_wr.root    = broot_q;
    end
  end

  // empty sub-intervals cost nothing
  assign cand = (p_lemp_q ? '0 : ra) + (p_remp_q ? '0 : rb);

  obst_tables u_tables (
    .clk_i       (clk_i),
    .w_we_i      (w_we),
    .w_waddr_i   (WAW'(in_key)),
    .w_wdata_i   (in_weight),
    .w_raddr_i   (w_raddr),
    .w_rdata_o   (w_rdata),
    .tbl_wr_i    (tbl_wr),
    .c_raddr_a_i (c_raddr_a),
    .c_raddr_b_i (c_raddr_b),
    .c_rdata_a_o (ra),
    .c_rdata_b_o (rb),
    .r_raddr_i   (r_raddr),
    .r_rdata_o   (r_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      key_count_q  <= 7'd1;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      span_q       <= '0;
      p_k_q        <= '0;
      p_v_q        <= 1'b0;
      p_lemp_q     <= 1'b0;
      p_remp_q     <= 1'b0;
      best_q       <= '0;
      sum_q        <= '0;
      broot_q      <= '0;
      q_ok_q       <= 1'b0;
      q_empty_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= 1'b0;
      out_status_q <= 1'b0;
      out_cost_q   <= '0;
      out_root_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        key_count_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      p_v_q <= (state_q == S_INIT) || (state_q == S_RUN);
      p_k_q <= k_q;

      // candidate root accumulation, one per cycle
      if (p_v_q) begin
        if (p_lemp_q || cand < best_q) begin
          best_q  <= cand;
          broot_q <= RW'(p_k_q);
        end
        sum_q <= (p_lemp_q ? '0 : sum_q) + CW'(w_rdata);
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (cmd)
              CMD_SOLVE: begin
                if (n_eff == '0) begin
                  out_valid_q  <= 1'b1;
                  out_kind_q   <= KIND_SOLVE;
                  out_cost_q   <= '0;
                  out_root_q   <= '0;
                  out_status_q <= 1'b0;
                end else begin
                  k_q     <= KW'(1);
                  state_q <= S_INIT;
                end
              end
              CMD_QUERY: begin
                q_ok_q    <= q_ok;
                q_empty_q <= ({1'b0, in_re} + 1'b1 == {1'b0, in_rs});
                state_q   <= S_QRD;
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          k_q <= k_q + 1'b1;
          if (k_q == n_eff) begin
            state_q <= S_INIT_END;
          end
        end
        S_INIT_END: begin
          if (n_eff == KW'(1)) begin
            state_q <= S_FIN_RD;
          end else begin
            span_q  <= KW'(1);
            i_q     <= KW'(1);
            j_q     <= KW'(2);
            k_q     <= KW'(1);
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          p_lemp_q <= (k_q == i_q);
          p_remp_q <= (k_q == j_q);
          k_q      <= k_q + 1'b1;
          if (k_q == j_q) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          if (j_q == n_eff) begin
            if (span_q + 1'b1 >= n_eff) begin
              state_q <= S_FIN_RD;
            end else begin
              span_q  <= span_q + 1'b1;
              i_q     <= KW'(1);
              j_q     <= span_q + KW'(2);
              k_q     <= KW'(1);
              state_q <= S_RUN;
            end
          end else begin
            i_q     <= i_q + 1'b1;
            j_q     <= j_q + 1'b1;
            k_q     <= i_q + 1'b1;
            state_q <= S_RUN;
          end
        end
        S_FIN_RD: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          out_valid_q  <= 1'b1;
          out_kind_q   <= KIND_SOLVE;
          out_cost_q   <= ra;
          out_root_q   <= r_rdata;
          out_status_q <= 1'b0;
          state_q      <= S_IDLE;
        end
        S_QRD: begin
          out_valid_q  <= 1'b1;
          out_kind_q   <= KIND_QUERY;
          out_cost_q   <= '0;
          out_root_q   <= (q_ok_q && !q_empty_q) ? r_rdata : '0;
          out_status_q <= !q_ok_q;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {4'd0, out_status_q, out_root_q, out_cost_q};

endmodule

// ----- bench/obst_checker.sv -----
// Checker for the optimal BST solver: watches the command, result and config beats,
// recomputes the cost and root tables itself and compares every result beat.
// Depends on obst_pkg.
module obst_checker import obst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  output int          fail_count,
  output int          pending_count,
  output int          solve_count,
  output int          query_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] cost;
    logic [RW-1:0] root;
    logic          status;
  } answer_t;

  answer_t          answer_q[$];
  logic [6:0]       n_keys;
  logic [WW-1:0]    wts[MAX_KEYS+1];
  longint unsigned  cost_tbl[MAX_KEYS+2][MAX_KEYS+1];
  logic [RW-1:0]    root_tbl[MAX_KEYS+2][MAX_KEYS+1];

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic build_tables(input int n);
    longint unsigned best, sum, c;
    int br, j;
    for (int i = 1; i <= n; i++) begin
      cost_tbl[i][i-1] = 0; root_tbl[i][i-1] = '0;
      cost_tbl[i][i] = wts[i]; root_tbl[i][i] = RW'(i);
    end
    cost_tbl[n+1][n] = 0; root_tbl[n+1][n] = '0;
    for (int span = 1; span < n; span++)
      for (int i = 1; i + span <= n; i++) begin
        j = i + span;
        best = cost_tbl[i][i-1] + cost_tbl[i+1][j];
        br = i; sum = 0;
        for (int k = i; k <= j; k++) begin
          c = cost_tbl[i][k-1] + cost_tbl[k+1][j];
          if (c < best) begin
            best = c; br = k;
          end
          sum += wts[k];
        end
        cost_tbl[i][j] = best + sum;
        root_tbl[i][j] = RW'(br);
      end
  endtask

  function automatic answer_t predict(input logic [1:0] cmd, input logic [39:0] d);
    answer_t a;
    int n, i, j;
    n = (n_keys > MAX_KEYS) ? MAX_KEYS : int'(n_keys);
    a = '0;
    if (cmd == CMD_SOLVE) begin
      a.kind = KIND_SOLVE;
      if (n > 0) begin
        a.cost = CW'(cost_tbl[1][n]);
        a.root = root_tbl[1][n];
      end
    end else begin
      i = d[29:23]; j = d[36:30];
      a.kind = KIND_QUERY;
      if (i >= 1 && i <= n + 1 && j + 1 >= i && j <= n) a.root = root_tbl[i][j];
      else a.status = 1'b1;
    end
    return a;
  endfunction

  assign pending_count = answer_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      n_keys = 7'd1;
      answer_q.delete();
      fail_count = 0; solve_count = 0; query_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) n_keys = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          CMD_LOAD: begin
            if (s_axis_tdata[6:0] >= 1 && s_axis_tdata[6:0] <= MAX_KEYS)
              wts[s_axis_tdata[6:0]] = s_axis_tdata[22:7];
          end
          CMD_SOLVE: begin
            build_tables((n_keys > MAX_KEYS) ? MAX_KEYS : int'(n_keys));
            answer_q.insert(answer_q.size(), predict(s_axis_tuser, s_axis_tdata));
            solve_count++;
          end
          CMD_QUERY: begin
            answer_q.insert(answer_q.size(), predict(s_axis_tuser, s_axis_tdata));
            query_count++;
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (answer_q.size() == 0) begin
          report("result beat with none pending", 1, 0);
        end else begin
          want = answer_q.pop_front();
          if (m_axis_tuser !== want.kind)
            report("result_kind", m_axis_tuser, want.kind);
          if (m_axis_tdata[27:0] !== want.cost)
            report("min_cost", m_axis_tdata[27:0], want.cost);
          if (m_axis_tdata[34:28] !== want.root)
            report("root_key", m_axis_tdata[34:28], want.root);
          if (m_axis_tdata[35] !== want.status)
            report("status", m_axis_tdata[35], want.status);
          if (m_axis_tdata[39:36] !== 4'd0)
            report("pad bits", m_axis_tdata[39:36], 0);
        end
      end
    end
  end
endmodule

// ----- bench/tb_top.sv -----
// Testbench top for optimal_bst_cost_and_roots: drives weight loads, solves and
// root queries across several key counts, with random idling on both sides.
// Depends on obst_pkg, optimal_bst_cost_and_roots and obst_checker.
module tb_top import obst_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;

  int  fail_count, pending_count, solve_count, query_count;
  bit  calm = 1'b0;           // no idling in the closing stretch
  int  n_cur = 1;             // key count as last written
  bit  solved_for_n = 1'b0;   // tables valid for current n
  longint cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stall bursts
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  optimal_bst_cost_and_roots i_dut (.*);

  obst_checker i_chk (.*);

  // tvalid stays high after the beat; drain, or a random idle in the next send, takes it down
  task automatic send(input logic [1:0] cmd, input int key, input int wt,
                      input int rs, input int re);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, 7'(re), 7'(rs), 16'(wt), 7'(key)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_keys(input int n);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 7'(n);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_cur = n;
    solved_for_n = 1'b0;
  endtask

  task automatic load_all(input int n, input int mode);
    int w;
    for (int k = 1; k <= ((n > MAX_KEYS) ? MAX_KEYS : n); k++) begin
      case (mode)
        0: w = $urandom_range(0, 65535);
        1: w = 65535;
        2: w = 0;
        default: w = $urandom_range(0, 3); // many ties
      endcase
      send(CMD_LOAD, k, w, 0, 0);
    end
  endtask

  // queries only touch entries a solve at the current n has filled
  task automatic random_query();
    int ne, i, j;
    ne = (n_cur > MAX_KEYS) ? MAX_KEYS : n_cur;
    if (solved_for_n && $urandom_range(0, 3) != 0) begin
      i = $urandom_range(1, ne + 1);
      j = $urandom_range(i - 1, ne);
    end else begin
      i = $urandom_range(0, 127);
      j = $urandom_range(0, 127);
      if (i >= 1 && i <= ne + 1 && j + 1 >= i && j <= ne) begin
        i = ne + 2; // push out of range; this branch sends only invalid ranges
      end
    end
    send(CMD_QUERY, 0, 0, i, j);
  endtask

  initial begin
    int sizes[$];
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset key count, extremes, ignored items
    load_all(1, 1);
    send(CMD_SOLVE, 0, 0, 0, 0);
    solved_for_n = 1'b1;
    send(CMD_QUERY, 0, 0, 1, 1);
    send(CMD_QUERY, 0, 0, 1, 0);
    send(CMD_QUERY, 0, 0, 2, 1);
    send(CMD_QUERY, 0, 0, 0, 0);
    send(CMD_QUERY, 0, 0, 127, 127);
    send(CMD_QUERY, 0, 0, 1, 2);
    send(CMD_NONE, 127, 65535, 127, 127);  // unused command
    send(CMD_LOAD, 0, 1234, 0, 0);         // key 0 ignored
    send(CMD_LOAD, 65, 1234, 0, 0);        // beyond range ignored
    send(CMD_LOAD, 127, 65535, 0, 0);
    set_keys(0);
    send(CMD_SOLVE, 0, 0, 0, 0);           // empty problem
    send(CMD_QUERY, 0, 0, 1, 0);
    send(CMD_QUERY, 0, 0, 1, 1);
    set_keys(64);
    load_all(64, 1);                        // largest weights at largest n
    send(CMD_SOLVE, 0, 0, 0, 0);
    solved_for_n = 1'b1;
    send(CMD_QUERY, 0, 0, 1, 64);
    send(CMD_QUERY, 0, 0, 65, 64);
    send(CMD_QUERY, 0, 0, 64, 65);
    set_keys(127);                          // clamps to the maximum
    send(CMD_SOLVE, 0, 0, 0, 0);
    solved_for_n = 1'b1;
    send(CMD_QUERY, 0, 0, 33, 64);

    // random phases, mostly small problems
    sizes = '{3, 1, 5, 2, 8, 4, 12, 6, 7, 20, 10, 3, 2, 5, 9, 1};
    foreach (sizes[p]) begin
      n = sizes[p];
      if (p == sizes.size() - 4) calm = 1'b1;
      set_keys(n);
      load_all(n, (p % 4 == 1) ? 3 : ((p == 4) ? 2 : 0));
      repeat ($urandom_range(2, 5)) random_query();
      send(CMD_SOLVE, 0, 0, 0, 0);
      solved_for_n = 1'b1;
      repeat ($urandom_range(4, 8)) begin
        case ($urandom_range(0, 9))
          0: send(CMD_LOAD, $urandom_range(0, 127), $urandom_range(0, 65535), 0, 0);
          1: send(CMD_NONE, $urandom_range(0, 127), $urandom_range(0, 65535),
                  $urandom_range(0, 127), $urandom_range(0, 127));
          default: random_query();
        endcase
      end
      // solve again over any weights changed by late loads
      send(CMD_SOLVE, 0, 0, 0, 0);
      repeat ($urandom_range(1, 3)) random_query();
    end

    drain();
    $display("covered %0d solves and %0d root queries over key counts 0 to 127",
             solve_count, query_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
